/* src/hdfst_pkg.sv */
// Shared types, codes, constants and size arithmetic for the health driven filter size tuner.
// No dependencies; every other file imports this package.
`default_nettype none

package hdfst_pkg;

    // Default thresholds, handed to the top level parameters
    localparam int STABLE_REPORTS_DEF       = 2;
    localparam int OVERLOAD_TICKS_DEF       = 3;
    localparam int COOLDOWN_CLEAR_TICKS_DEF = 5;
    localparam int PROBE_AFTER_TICKS_DEF    = 2;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CODE_W   = 4;
    localparam int REG_W    = 3;
    localparam int MAP_W    = 4;
    localparam int CLASS_W  = 3;
    localparam int SIZE_W   = 12;
    localparam int STEP_W   = 8;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Highest meaningful health codes per stage
    localparam int REG_MAX_CODE = 4;
    localparam int MAP_MAX_CODE = 9;

    // Operation codes
    localparam logic [OP_W-1:0] OP_REG_REPORT = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP_REPORT = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK       = 2'd2;

    // System health classes
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN      = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_HEALTHY      = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_REG_ISSUES   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_FEW_FEATURES = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_ICP_UNSTABLE = 3'd4;

    // Health codes referenced by the ranking
    localparam logic [MAP_W-1:0] MAP_HEALTHY       = 4'd0;
    localparam logic [MAP_W-1:0] MAP_ICP_FIRST     = 4'd1;
    localparam logic [MAP_W-1:0] MAP_ICP_LAST      = 4'd3;
    localparam logic [MAP_W-1:0] MAP_FEATURE_FIRST = 4'd4;
    localparam logic [MAP_W-1:0] MAP_FEATURE_LAST  = 4'd8;
    localparam logic [REG_W-1:0] REG_HEALTHY       = 3'd0;
    localparam logic [REG_W-1:0] REG_ISSUE_FIRST   = 3'd1;
    localparam logic [REG_W-1:0] REG_ISSUE_LAST    = 3'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SMALL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_NORMAL  = 3'd6;

    // Reset values
    localparam logic [SIZE_W-1:0] CORNER_MIN_RST  = 12'd50;
    localparam logic [SIZE_W-1:0] CORNER_MAX_RST  = 12'd400;
    localparam logic [SIZE_W-1:0] SURF_MIN_RST    = 12'd100;
    localparam logic [SIZE_W-1:0] SURF_MAX_RST    = 12'd800;
    localparam logic [STEP_W-1:0] STEP_SMALL_RST  = 8'd5;
    localparam logic [STEP_W-1:0] STEP_NORMAL_RST = 8'd20;
    localparam logic [SIZE_W-1:0] CORNER_RST      = 12'd200;
    localparam logic [SIZE_W-1:0] SURF_RST        = 12'd400;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CODE_W-1:0] health_code;
    } item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] system_health;
        logic [SIZE_W-1:0]  corner_size;
        logic [SIZE_W-1:0]  surf_size;
        logic               sizes_changed;
        logic               cooldown_active;
        logic [REG_W-1:0]   stable_reg_health;
        logic [MAP_W-1:0]   stable_map_health;
    } result_t;

    typedef struct packed {
        logic              adapt_enable;
        logic [SIZE_W-1:0] corner_min;
        logic [SIZE_W-1:0] corner_max;
        logic [SIZE_W-1:0] surf_min;
        logic [SIZE_W-1:0] surf_max;
        logic [STEP_W-1:0] step_small;
        logic [STEP_W-1:0] step_normal;
    } cfg_t;

    // Tuner state as seen after the current transaction
    typedef struct packed {
        logic [CLASS_W-1:0] health_class;
        logic [SIZE_W-1:0]  corner_size;
        logic [SIZE_W-1:0]  surf_size;
        logic               sizes_changed;
        logic               cooldown_active;
    } tick_status_t;

    // Saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Step up, limited at hi
    function automatic logic [SIZE_W-1:0] size_step_up(input logic [SIZE_W-1:0] v,
                                                       input logic [STEP_W:0]   step,
                                                       input logic [SIZE_W-1:0] hi);
        logic [SIZE_W:0] sum;
        sum = {1'b0, v} + {{(SIZE_W-STEP_W){1'b0}}, step};
        return (sum > {1'b0, hi}) ? hi : sum[SIZE_W-1:0];
    endfunction

    // Step down, limited at lo; an underflow lands on lo
    function automatic logic [SIZE_W-1:0] size_step_down(input logic [SIZE_W-1:0] v,
                                                         input logic [STEP_W:0]   step,
                                                         input logic [SIZE_W-1:0] lo);
        logic [SIZE_W-1:0] step_ext;
        logic [SIZE_W-1:0] diff;
        step_ext = {{(SIZE_W-STEP_W-1){1'b0}}, step};
        diff = v - step_ext;
        if (step_ext >= v)
            return lo;
        return (diff < lo) ? lo : diff;
    endfunction

    // Clamp to [lo, hi]; crossed bounds give lo
    function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lo,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] t;
        t = (v > hi) ? hi : v;
        return (t < lo) ? lo : t;
    endfunction

endpackage

`default_nettype wire

/* src/hdfst_stabilizer.sv */
// Report stabilizer: tracks repeats of one stage's health code and latches a stable code.
// Depends on hdfst_pkg.
`default_nettype none

module hdfst_stabilizer
    import hdfst_pkg::*;
#(
    parameter int W              = REG_W,
    parameter int MAX_CODE       = REG_MAX_CODE,
    parameter int STABLE_REPORTS = STABLE_REPORTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              report,
    input  wire logic [CODE_W-1:0] code,
    output logic      [W-1:0]      stable_code,
    output logic      [W-1:0]      stable_next
);

    logic [W-1:0]     last_code_reg, last_code_next;
    logic [CNT_W-1:0] repeat_count_reg, repeat_count_next;
    logic [W-1:0]     stable_code_reg;
    logic [W-1:0]     code_sat;

    // Out of range codes count as the last ("other") code
    assign code_sat = (code > CODE_W'(MAX_CODE)) ? W'(MAX_CODE) : code[W-1:0];

    // Repeat tracking
    always_comb
    begin
        last_code_next    = last_code_reg;
        repeat_count_next = repeat_count_reg;
        stable_next       = stable_code_reg;
        if (report)
        begin
            if (code_sat == last_code_reg)
            begin
                repeat_count_next = sat_inc(repeat_count_reg);
            end
            else
            begin
                last_code_next    = code_sat;
                repeat_count_next = CNT_W'(1);
            end
            if (repeat_count_next >= CNT_W'(STABLE_REPORTS))
                stable_next = last_code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg    <= '0;
            repeat_count_reg <= '0;
            stable_code_reg  <= '0;
        end
        else
        begin
            last_code_reg    <= last_code_next;
            repeat_count_reg <= repeat_count_next;
            stable_code_reg  <= stable_next;
        end
    end

    assign stable_code = stable_code_reg;

endmodule

`default_nettype wire

/* src/hdfst_tick_unit.sv */
// Tick unit: ranks stable codes into a health class, runs the overload and cooldown
// counters and steps and clamps both filter sizes. Depends on hdfst_pkg.
`default_nettype none

module hdfst_tick_unit
    import hdfst_pkg::*;
#(
    parameter int OVERLOAD_TICKS       = OVERLOAD_TICKS_DEF,
    parameter int COOLDOWN_CLEAR_TICKS = COOLDOWN_CLEAR_TICKS_DEF,
    parameter int PROBE_AFTER_TICKS    = PROBE_AFTER_TICKS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tick,
    input  wire cfg_t             cfg,
    input  wire logic [REG_W-1:0] stable_reg,
    input  wire logic [MAP_W-1:0] stable_map,
    output tick_status_t          status
);

    logic [CLASS_W-1:0] class_reg;
    logic [CNT_W-1:0]   icp_count_reg, icp_count_next;
    logic [CNT_W-1:0]   healthy_count_reg, healthy_count_next;
    logic               cooldown_reg, cooldown_next;
    logic [SIZE_W-1:0]  corner_reg, surf_reg;

    logic [CLASS_W-1:0] cls;
    logic               overload;
    logic               move_en, move_up;
    logic [STEP_W:0]    move_step;
    logic [SIZE_W-1:0]  corner_a, surf_a, corner_b, surf_b, corner_c, surf_c;

    // Priority ranking of the stable codes
    always_comb
    begin
        if (stable_map >= MAP_ICP_FIRST && stable_map <= MAP_ICP_LAST)
            cls = CLS_ICP_UNSTABLE;
        else if (stable_map >= MAP_FEATURE_FIRST && stable_map <= MAP_FEATURE_LAST)
            cls = CLS_FEW_FEATURES;
        else if (stable_reg >= REG_ISSUE_FIRST && stable_reg <= REG_ISSUE_LAST)
            cls = CLS_REG_ISSUES;
        else if (stable_map == MAP_HEALTHY && stable_reg == REG_HEALTHY)
            cls = CLS_HEALTHY;
        else
            cls = CLS_UNKNOWN;
    end

    // Overload and cooldown counters
    always_comb
    begin
        icp_count_next     = icp_count_reg;
        healthy_count_next = healthy_count_reg;
        cooldown_next      = cooldown_reg;
        overload           = 1'b0;
        case (cls)
            CLS_ICP_UNSTABLE:
            begin
                icp_count_next     = sat_inc(icp_count_reg);
                healthy_count_next = '0;
                if (icp_count_next >= CNT_W'(OVERLOAD_TICKS) && !cooldown_reg)
                begin
                    overload      = 1'b1;
                    cooldown_next = 1'b1;
                end
            end
            CLS_HEALTHY:
            begin
                icp_count_next     = '0;
                healthy_count_next = sat_inc(healthy_count_reg);
                if (cooldown_reg && healthy_count_next >= CNT_W'(COOLDOWN_CLEAR_TICKS))
                begin
                    cooldown_next      = 1'b0;
                    healthy_count_next = '0;
                end
            end
            CLS_FEW_FEATURES:
            begin
                healthy_count_next = '0;
            end
            default:
            begin
                healthy_count_next = '0;
                icp_count_next     = '0;
            end
        endcase
    end

    // Class driven step, chosen after the counter update
    always_comb
    begin
        move_en   = 1'b0;
        move_up   = 1'b1;
        move_step = {1'b0, cfg.step_small};
        case (cls)
            CLS_FEW_FEATURES:
            begin
                move_en   = !cooldown_next;
                move_up   = 1'b0;
                move_step = {1'b0, cfg.step_normal};
            end
            CLS_ICP_UNSTABLE:
            begin
                move_en = 1'b1;
                move_up = cooldown_next || (stable_reg == REG_HEALTHY);
            end
            CLS_HEALTHY:
            begin
                move_en = !cooldown_next &&
                          (healthy_count_next >= CNT_W'(PROBE_AFTER_TICKS));
            end
            default:
            begin
                move_en = 1'b0;
            end
        endcase
    end

    // Size path: overload jump, class step, final clamp
    always_comb
    begin
        corner_a = overload ? size_step_up(corner_reg, {cfg.step_normal, 1'b0}, cfg.corner_max)
                            : corner_reg;
        surf_a   = overload ? size_step_up(surf_reg, {cfg.step_normal, 1'b0}, cfg.surf_max)
                            : surf_reg;
        if (!move_en)
        begin
            corner_b = corner_a;
            surf_b   = surf_a;
        end
        else if (move_up)
        begin
            corner_b = size_step_up(corner_a, move_step, cfg.corner_max);
            surf_b   = size_step_up(surf_a, move_step, cfg.surf_max);
        end
        else
        begin
            corner_b = size_step_down(corner_a, move_step, cfg.corner_min);
            surf_b   = size_step_down(surf_a, move_step, cfg.surf_min);
        end
        corner_c = size_clamp(corner_b, cfg.corner_min, cfg.corner_max);
        surf_c   = size_clamp(surf_b, cfg.surf_min, cfg.surf_max);
    end

    // State after this transaction
    always_comb
    begin
        if (tick)
        begin
            status.health_class    = cls;
            status.corner_size     = corner_c;
            status.surf_size       = surf_c;
            status.sizes_changed   = (corner_c != corner_reg) || (surf_c != surf_reg);
            status.cooldown_active = cooldown_next;
        end
        else
        begin
            status.health_class    = class_reg;
            status.corner_size     = corner_reg;
            status.surf_size       = surf_reg;
            status.sizes_changed   = 1'b0;
            status.cooldown_active = cooldown_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg         <= CLS_UNKNOWN;
            icp_count_reg     <= '0;
            healthy_count_reg <= '0;
            cooldown_reg      <= 1'b0;
            corner_reg        <= CORNER_RST;
            surf_reg          <= SURF_RST;
        end
        else if (tick)
        begin
            class_reg         <= cls;
            icp_count_reg     <= icp_count_next;
            healthy_count_reg <= healthy_count_next;
            cooldown_reg      <= cooldown_next;
            corner_reg        <= corner_c;
            surf_reg          <= surf_c;
        end
    end

endmodule

`default_nettype wire

/* src/health_driven_filter_size_tuner.sv */
// Health driven filter size tuner, top level: input register, report stabilizers,
// tick unit, configuration registers and result register. Depends on hdfst_pkg.
//
// Usage
//   item channel   : item_valid / item_ready / item (operation, health_code).
//                    Registration and mapping reports feed the stabilizers; a tick with
//                    adapt_enable set updates health class, overload counters and both filter sizes.
//   result channel : result_valid / result_ready / result; exactly one result per
//                    transaction, in order.
//   config port    : cfg_we / cfg_index / cfg_data, written on any edge with cfg_we
//                    high; write only while no transaction is in flight.
// Timing
//   A transaction accepted on the item channel is captured in the input register
//   and its result is registered in the result register when that register is
//   free or being taken. Throughput is one transaction per cycle while the receiver
//   keeps up; the state loops are the updates of the stabilizers and tick unit.
// Reset (rst_n low, asynchronous) empties both stages, restores the register
// defaults, the stabilizer state and sizes 200 / 400 thousandths.
// When the receiver stalls, the result holds and the input register still takes
// one more transaction; item_ready then drops until the result is taken.
`default_nettype none

module health_driven_filter_size_tuner
    import hdfst_pkg::*;
#(
    parameter int STABLE_REPORTS       = STABLE_REPORTS_DEF,
    parameter int OVERLOAD_TICKS       = OVERLOAD_TICKS_DEF,
    parameter int COOLDOWN_CLEAR_TICKS = COOLDOWN_CLEAR_TICKS_DEF,
    parameter int PROBE_AFTER_TICKS    = PROBE_AFTER_TICKS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic         stage_valid_reg, stage_valid_next;
    item_t        stage_item_reg;
    logic         result_valid_reg, result_valid_next;
    result_t      result_reg;
    cfg_t         cfg_reg;
    logic         advance;
    logic         reg_report, map_report, tick;
    logic [REG_W-1:0] stable_reg, stable_reg_next;
    logic [MAP_W-1:0] stable_map, stable_map_next;
    tick_status_t status;

    // Handshake: stage moves on when the result register is free or being drained
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_valid && item_ready)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    // Operation decode of the staged transaction
    assign reg_report = advance && (stage_item_reg.operation == OP_REG_REPORT);
    assign map_report = advance && (stage_item_reg.operation == OP_MAP_REPORT);
    assign tick       = advance && (stage_item_reg.operation == OP_TICK) &&
                        cfg_reg.adapt_enable;

    hdfst_stabilizer #(
        .W              (REG_W),
        .MAX_CODE       (REG_MAX_CODE),
        .STABLE_REPORTS (STABLE_REPORTS)
    ) u_reg_stab (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (reg_report),
        .code        (stage_item_reg.health_code),
        .stable_code (stable_reg),
        .stable_next (stable_reg_next)
    );

    hdfst_stabilizer #(
        .W              (MAP_W),
        .MAX_CODE       (MAP_MAX_CODE),
        .STABLE_REPORTS (STABLE_REPORTS)
    ) u_map_stab (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (map_report),
        .code        (stage_item_reg.health_code),
        .stable_code (stable_map),
        .stable_next (stable_map_next)
    );

    hdfst_tick_unit #(
        .OVERLOAD_TICKS       (OVERLOAD_TICKS),
        .COOLDOWN_CLEAR_TICKS (COOLDOWN_CLEAR_TICKS),
        .PROBE_AFTER_TICKS    (PROBE_AFTER_TICKS)
    ) u_tick (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg        (cfg_reg),
        .stable_reg (stable_reg),
        .stable_map (stable_map),
        .status     (status)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adapt_enable <= 1'b1;
            cfg_reg.corner_min   <= CORNER_MIN_RST;
            cfg_reg.corner_max   <= CORNER_MAX_RST;
            cfg_reg.surf_min     <= SURF_MIN_RST;
            cfg_reg.surf_max     <= SURF_MAX_RST;
            cfg_reg.step_small   <= STEP_SMALL_RST;
            cfg_reg.step_normal  <= STEP_NORMAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADAPT_ENABLE: cfg_reg.adapt_enable <= cfg_data[0];
                CFG_CORNER_MIN:   cfg_reg.corner_min   <= cfg_data[SIZE_W-1:0];
                CFG_CORNER_MAX:   cfg_reg.corner_max   <= cfg_data[SIZE_W-1:0];
                CFG_SURF_MIN:     cfg_reg.surf_min     <= cfg_data[SIZE_W-1:0];
                CFG_SURF_MAX:     cfg_reg.surf_max     <= cfg_data[SIZE_W-1:0];
                CFG_STEP_SMALL:   cfg_reg.step_small   <= cfg_data[STEP_W-1:0];
                CFG_STEP_NORMAL:  cfg_reg.step_normal  <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_item_reg <= item;
        if (advance)
        begin
            result_reg.system_health     <= status.health_class;
            result_reg.corner_size       <= status.corner_size;
            result_reg.surf_size         <= status.surf_size;
            result_reg.sizes_changed     <= status.sizes_changed;
            result_reg.cooldown_active   <= status.cooldown_active;
            result_reg.stable_reg_health <= stable_reg_next;
            result_reg.stable_map_health <= stable_map_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* src/hdfst_checker.sv */
// Port level checks for the health driven filter size tuner, bound to the top level.
// Depends on hdfst_pkg and health_driven_filter_size_tuner.
`default_nettype none

module hdfst_checker
    import hdfst_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    // A stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A new result is preceded by an accepted input transaction that caused it
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a matching input transaction");

    // With the result register empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result register");

    // Reported codes stay within their encodings
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.system_health <= CLS_ICP_UNSTABLE &&
                         result.stable_reg_health <= REG_W'(REG_MAX_CODE) &&
                         result.stable_map_health <= MAP_W'(MAP_MAX_CODE))
        else $error("result code out of range");

endmodule

bind health_driven_filter_size_tuner hdfst_checker u_hdfst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
